FILE: hw/rtl/saa_pkg.sv
package saa_pkg;

  localparam int MaxRegionsDef = 256;
  localparam int MaxDimDef = 8192;
  localparam int UvFracBitsDef = 16;

  localparam int DimW = 14;
  localparam int UvW = 17;
  localparam int StW = 3;
  localparam int IdW = 8;
  localparam int RidW = 9;

  localparam logic [DimW-1:0] DimMin = 14'd16;
  localparam logic [DimW-1:0] DimReset = 14'd1024;

  typedef enum logic [StW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_TOO_WIDE = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [DimW-1:0] tex_width;
    logic [DimW-1:0] tex_height;
    logic [RidW-1:0] region_id;
  } in_item_t;

  typedef struct packed {
    logic [StW-1:0] status;
    logic [IdW-1:0] assigned_id;
    logic [UvW-1:0] u_start;
    logic [UvW-1:0] v_start;
    logic [UvW-1:0] u_end;
    logic [UvW-1:0] v_end;
  } out_item_t;

  // Region record stored in the table.
  typedef struct packed {
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } region_t;

endpackage

FILE: hw/rtl/saa_frac_div.sv
module saa_frac_div #(
  parameter int UV_FRAC_BITS = saa_pkg::UvFracBitsDef
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [14:0]             coord,
  input  logic [13:0]             dim,
  output logic                    done,
  output logic [saa_pkg::UvW-1:0] frac
);
  import saa_pkg::*;

  localparam int QW = 15 + UV_FRAC_BITS;
  localparam int CntW = $clog2(QW + 1);
  localparam logic [QW-1:0] One = QW'(1) << UV_FRAC_BITS;

  logic [QW-1:0]   dividend;
  logic [QW-1:0]   quot;
  logic [14:0]     rem;
  logic [13:0]     divisor;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [15:0]     trial;
  logic [14:0]     rem_shift;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial = {rem, dividend[QW-1]} - {2'b00, divisor};
    rem_shift = {rem[13:0], dividend[QW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(QW);
        dividend <= QW'(coord) << UV_FRAC_BITS;
        divisor <= dim;
        rem <= '0;
        quot <= '0;
      end else if (busy) begin
        dividend <= dividend << 1;
        if (!trial[15]) begin
          rem <= trial[14:0];
          quot <= {quot[QW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quot <= {quot[QW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Saturate to one.
  always_comb begin
    if (quot > One) frac = UvW'(One);
    else frac = UvW'(quot);
  end
endmodule

FILE: hw/rtl/shelf_atlas_allocator_core.sv
// Shelf next-fit atlas allocator.
// Input channel (in_valid/in_stall, in_data) carries one transaction per
// request: add a padded rectangle, or query the UV rect of a stored region.
// Output channel (out_valid/out_stall, out_data) returns exactly one result
// transaction per request, in order.
// Configuration: cfg_we writes atlas_width (index 0) or atlas_height
// (index 1), saturated to 16..MAX_DIM (capped at 16383). Write only while idle.
// Sequence: an add is handled in S_ADD (shelf update and table write, result into
// the output register), then marked valid from S_DONE; an unknown id is handled
// likewise in S_RD. A query of a known region is paced by the single shared
// serial divider, which forms the four Q16 fractions one after another; each
// division yields 31 quotient bits, one bit per cycle.
// One request is in flight at a time; the next is accepted only after the
// result has been taken, or in the cycle in which it is taken.
// Reset clears the shelf state and region count and restores both
// dimensions to 1024; the region table memory is not cleared.
// A stalled result holds in the output register until taken.
module shelf_atlas_allocator_core #(
  parameter int MAX_REGIONS = saa_pkg::MaxRegionsDef,
  parameter int MAX_DIM = saa_pkg::MaxDimDef,
  parameter int UV_FRAC_BITS = saa_pkg::UvFracBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  saa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output saa_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [13:0]         cfg_wdata
);
  import saa_pkg::*;

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CntW = $clog2(MAX_REGIONS + 1);
  localparam logic [DimW-1:0] DimMax =
    (MAX_DIM > 16383) ? 14'h3FFF : DimW'(MAX_DIM);
  localparam logic [UvW-1:0] UvOne = UvW'(1) << UV_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_RD, S_DIV_START, S_DIV_WAIT, S_DONE
  } state_t;

  state_t          state;
  logic [DimW-1:0] atlas_width, atlas_height;
  logic [DimW-1:0] shelf_cursor_x, shelf_top_y, shelf_tallest;
  logic [CntW-1:0] regions_used;
  in_item_t        req;
  region_t         mem [MAX_REGIONS];
  region_t         rd_data;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  region_t         mem_wdata;
  logic [1:0]      phase;
  logic [UvW-1:0]  fr [4];
  logic            div_start, div_done;
  logic [14:0]     div_coord;
  logic [13:0]     div_dim;
  logic [UvW-1:0]  div_frac;
  logic [DimW-1:0] cfg_clamped;

  // Add datapath, computed from the registered request.
  logic [14:0] tw, th;
  logic [14:0] sum_x, sum_y;
  logic [DimW-1:0] top_eff, cur_eff, tall_eff;
  logic        full, too_wide, no_space;
  out_item_t   add_res;
  logic [DimW-1:0] cursor_next, tallest_next;

  always_comb begin
    tw = {1'b0, req.tex_width} + 15'd2;
    th = {1'b0, req.tex_height} + 15'd2;
    full = (regions_used >= CntW'(MAX_REGIONS));
    too_wide = tw > {1'b0, atlas_width};
    sum_x = {1'b0, shelf_cursor_x} + tw;
    if (sum_x > {1'b0, atlas_width}) begin
      top_eff = shelf_top_y + shelf_tallest;
      cur_eff = '0;
      tall_eff = '0;
    end else begin
      top_eff = shelf_top_y;
      cur_eff = shelf_cursor_x;
      tall_eff = shelf_tallest;
    end
    sum_y = {1'b0, top_eff} + th;
    no_space = sum_y > {1'b0, atlas_height};
  end

  // Add result and next shelf values.
  always_comb begin
    add_res = '0;
    cursor_next = cur_eff;
    tallest_next = tall_eff;
    if (full) add_res.status = ST_FULL;
    else if (too_wide) add_res.status = ST_TOO_WIDE;
    else if (no_space) add_res.status = ST_NO_SPACE;
    else begin
      add_res.status = ST_OK;
      add_res.assigned_id = IdW'(regions_used);
      cursor_next = DimW'({1'b0, cur_eff} + tw);
      if (th > {1'b0, tall_eff}) tallest_next = th[DimW-1:0];
    end
  end

  // Configuration saturation.
  always_comb begin
    if (cfg_wdata < DimMin) cfg_clamped = DimMin;
    else if (cfg_wdata > DimMax) cfg_clamped = DimMax;
    else cfg_clamped = cfg_wdata;
  end

  // Region table memory.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[mem_raddr];
  end

  assign mem_raddr = req.region_id[AW-1:0];
  assign mem_waddr = regions_used[AW-1:0];
  assign mem_we = (state == S_ADD) && !full && !too_wide && !no_space;
  assign mem_wdata = '{x: cur_eff + 1'b1, y: top_eff + 1'b1,
                       w: req.tex_width, h: req.tex_height};

  // Divider operand select per phase.
  always_comb begin
    case (phase)
      2'd0: begin div_coord = {1'b0, rd_data.x}; div_dim = atlas_width; end
      2'd1: begin div_coord = {1'b0, rd_data.y}; div_dim = atlas_height; end
      2'd2: begin div_coord = {1'b0, rd_data.x} + {1'b0, rd_data.w};
                  div_dim = atlas_width; end
      default: begin div_coord = {1'b0, rd_data.y} + {1'b0, rd_data.h};
                     div_dim = atlas_height; end
    endcase
  end

  assign div_start = (state == S_DIV_START);

  saa_frac_div #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .coord(div_coord),
    .dim(div_dim), .done(div_done), .frac(div_frac)
  );

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  // Control sequencer and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      atlas_width <= DimReset;
      atlas_height <= DimReset;
      shelf_cursor_x <= '0;
      shelf_top_y <= '0;
      shelf_tallest <= '0;
      regions_used <= '0;
      phase <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:  atlas_width <= cfg_clamped;
          CFG_HEIGHT: atlas_height <= cfg_clamped;
          default: ;
        endcase
      end
      // The output register is always empty by the time a result is done.
      if (state == S_DONE) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req <= in_data;
            state <= (in_data.opcode == OP_ADD) ? S_ADD : S_RD;
          end
        end
        S_ADD: begin
          out_data <= add_res;
          if (!full && !too_wide) begin
            shelf_top_y <= top_eff;
            shelf_cursor_x <= cursor_next;
            shelf_tallest <= tallest_next;
            if (!no_space) regions_used <= regions_used + 1'b1;
          end
          state <= S_DONE;
        end
        S_RD: begin
          if ({{(RidW+1){1'b0}}, req.region_id} >= (RidW+1+CntW)'(regions_used)) begin
            out_data <= '{status: ST_UNKNOWN, assigned_id: '0, u_start: '0,
                          v_start: '0, u_end: UvOne, v_end: UvOne};
            state <= S_DONE;
          end else begin
            phase <= '0;
            state <= S_DIV_START;
          end
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            fr[phase] <= div_frac;
            phase <= phase + 1'b1;
            if (phase == 2'd3) begin
              out_data <= '{status: ST_OK, assigned_id: '0, u_start: fr[0],
                            v_start: fr[1], u_end: fr[2], v_end: div_frac};
              state <= S_DONE;
            end else state <= S_DIV_START;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
